// ===== rtl/calendar_date_stepper_defines.svh =====
// Assertion macros used by the calendar date stepper top level.
`ifndef CALENDAR_DATE_STEPPER_DEFINES_SVH
`define CALENDAR_DATE_STEPPER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CDS_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CDS_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cds_pkg.sv =====
// Types, codes and calendar arithmetic helpers for the date stepper.
package cds_pkg;

  localparam int YearW = 13;

  localparam logic [1:0] UNIT_DAY   = 2'd0;
  localparam logic [1:0] UNIT_MONTH = 2'd1;
  localparam logic [1:0] UNIT_YEAR  = 2'd2;
  localparam logic [1:0] UNIT_NONE  = 2'd3;

  localparam logic [1:0] YR_KEEP = 2'd0;
  localparam logic [1:0] YR_UP   = 2'd1;
  localparam logic [1:0] YR_DOWN = 2'd2;

  localparam logic [11:0] BASE_YEAR_RESET = 12'd2000;
  localparam logic [YearW-1:0] WEEK_YEAR_BIAS = 13'd400;

  // Reciprocals: x/25 = (x*1311)>>15 for x < 4681, x/7 = (x*9363)>>16 for x < 13107.
  localparam logic [21:0] DIV25_MUL = 22'd1311;
  localparam logic [26:0] DIV7_MUL  = 27'd9363;

  typedef struct packed {
    logic [1:0] unit;
    logic       fwd;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } req_t;

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [6:0]       yoff;
    logic             fwd;
    logic [1:0]       unit;
    logic [YearW-1:0] year;
    logic             leap_prev;
    logic             leap_cur;
    logic             leap_next;
  } s1_t;

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [6:0]       yoff;
    logic [YearW-1:0] wyear;
  } s2_t;

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [6:0]       yoff;
    logic [YearW-1:0] sum;
  } s3_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } res_t;

  function automatic logic [6:0] div25(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * DIV25_MUL;
    return p[21:15];
  endfunction

  function automatic logic [2:0] mod7(input logic [YearW-1:0] x);
    logic [26:0]      p;
    logic [YearW-1:0] r;
    p = 27'(x) * DIV7_MUL;
    r = x - 13'(p[26:16]) * 13'd7;
    return r[2:0];
  endfunction

  // A year divisible by 100 is y = 100*q, and then divisible by 400 when q is divisible by 4.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [6:0]  q;
    logic [10:0] r;
    q = div25(y[12:2]);
    r = y[12:2] - 11'(q) * 11'd25;
    return (y[1:0] == 2'b00) && ((r != 11'd0) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_off(input logic [3:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== rtl/calendar_date_stepper.sv =====
// Calendar date stepper top level: streaming ports, base year register, pipeline.
// Throughput: one request per cycle while m_tready does not stall the output.
// Four register stages, the last being the output register.
// A stalled output holds its result; empty stages upstream keep taking requests.
// Reset clears every stage's valid bit and loads base_year with 2000.
`include "calendar_date_stepper_defines.svh"

module calendar_date_stepper #(
  parameter int MAX_YEAR_OFFSET = 127
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // day_in, month_in, year_in, direction_forward, step_unit
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // day_out, month_out, year_out, weekday
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data   // base_year
);
  import cds_pkg::*;

  logic [11:0] base_year;
  req_t        req;
  logic        v1;
  logic        r1;
  s1_t         s1;
  logic        v2;
  logic        r2;
  s2_t         s2;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign req       = req_t'(s_tdata[18:0]);
  assign m_tdata   = {5'd0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_year <= BASE_YEAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_year <= cfg_data;
    end
  end

  cds_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (req),
    .base_year (base_year),
    .out_valid (v1),
    .out_ready (r1),
    .out_s1    (s1)
  );

  cds_step #(
    .MAX_YEAR_OFFSET (MAX_YEAR_OFFSET)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .in_s1     (s1),
    .out_valid (v2),
    .out_ready (r2),
    .out_s2    (s2)
  );

  cds_wday u_wday (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .in_s2     (s2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // An empty output register always lets the whole pipeline move.
  `CDS_ASSERT_NOW(a_ready_when_out_empty, clk, rst, !m_tvalid, s_tready,
    "input not ready while output register is empty")

  `CDS_ASSERT_NOW(a_month_range, clk, rst, m_tvalid,
    (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12), "result month out of range")

  `CDS_ASSERT_NOW(a_weekday_range, clk, rst, m_tvalid,
    m_tdata[18:16] != 3'd0, "result weekday is zero")

  // A stalled result stays valid and unchanged until it is taken.
  `CDS_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "stalled result changed or dropped")

endmodule

// ===== rtl/cds_prep.sv =====
// First stage: month fix, full year and leap flags for the year and its neighbors.
module cds_prep (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cds_pkg::req_t in_req,
  input  logic [11:0]   base_year,
  output logic          out_valid,
  input  logic          out_ready,
  output cds_pkg::s1_t  out_s1
);
  import cds_pkg::*;

  logic [3:0]       month_fix;
  logic [YearW-1:0] year;
  logic [YearW-1:0] year_prev;
  logic [YearW-1:0] year_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    month_fix = in_req.month;
    if (in_req.month == 4'd0 || in_req.month > 4'd12) begin
      month_fix = 4'd1;
    end
    year      = 13'(base_year) + 13'(in_req.year);
    year_prev = year - 13'd1;
    year_next = year + 13'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_s1.day       <= in_req.day;
      out_s1.month     <= month_fix;
      out_s1.yoff      <= in_req.year;
      out_s1.fwd       <= in_req.fwd;
      out_s1.unit      <= in_req.unit;
      out_s1.year      <= year;
      out_s1.leap_prev <= is_leap(year_prev);
      out_s1.leap_cur  <= is_leap(year);
      out_s1.leap_next <= is_leap(year_next);
    end
  end

endmodule

// ===== rtl/cds_step.sv =====
// Second stage: day, month or year step with carries, saturation and day clamp.
module cds_step #(
  parameter int MAX_YEAR_OFFSET = 127
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cds_pkg::s1_t in_s1,
  output logic         out_valid,
  input  logic         out_ready,
  output cds_pkg::s2_t out_s2
);
  import cds_pkg::*;

  localparam logic [9:0] MaxOff = 10'(MAX_YEAR_OFFSET);

  logic             can_up;
  logic             can_dn;
  logic [4:0]       len0;
  logic [4:0]       len1;
  logic [3:0]       month_up;
  logic             carry;
  logic [1:0]       ydir;
  logic [4:0]       day_n;
  logic [3:0]       month_n;
  logic [4:0]       day_c;
  logic             leap_sel;
  logic [YearW-1:0] year_sel;
  logic [7:0]       yoff_n;
  logic [YearW-1:0] wyear;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    can_up   = 10'(in_s1.yoff) < MaxOff;
    can_dn   = in_s1.yoff != 7'd0;
    len0     = month_len(in_s1.month, in_s1.leap_cur);
    carry    = in_s1.month == 4'd12;
    month_up = carry ? 4'd1 : in_s1.month + 4'd1;
    ydir     = YR_KEEP;
    day_n    = in_s1.day;
    month_n  = in_s1.month;

    case (in_s1.unit)
      UNIT_DAY: begin
        if (in_s1.fwd) begin
          if (in_s1.day >= len0) begin
            day_n   = 5'd1;
            month_n = month_up;
            if (carry && can_up) begin
              ydir = YR_UP;
            end
          end else begin
            day_n = in_s1.day + 5'd1;
          end
        end else begin
          // A step back from the first day wraps within the same month.
          day_n = (in_s1.day > 5'd1) ? in_s1.day - 5'd1 : len0;
        end
      end
      UNIT_MONTH: begin
        if (in_s1.fwd) begin
          month_n = month_up;
          if (carry && can_up) begin
            ydir = YR_UP;
          end
        end else begin
          month_n = (in_s1.month > 4'd1) ? in_s1.month - 4'd1 : 4'd12;
        end
      end
      UNIT_YEAR: begin
        if (in_s1.fwd && can_up) begin
          ydir = YR_UP;
        end else if (!in_s1.fwd && can_dn) begin
          ydir = YR_DOWN;
        end
      end
      default: begin
      end
    endcase

    case (ydir)
      YR_UP: begin
        leap_sel = in_s1.leap_next;
        year_sel = in_s1.year + 13'd1;
        yoff_n   = 8'(in_s1.yoff) + 8'd1;
      end
      YR_DOWN: begin
        leap_sel = in_s1.leap_prev;
        year_sel = in_s1.year - 13'd1;
        yoff_n   = 8'(in_s1.yoff) - 8'd1;
      end
      default: begin
        leap_sel = in_s1.leap_cur;
        year_sel = in_s1.year;
        yoff_n   = 8'(in_s1.yoff);
      end
    endcase

    len1  = month_len(month_n, leap_sel);
    day_c = day_n;
    if (in_s1.unit != UNIT_NONE) begin
      if (day_n > len1) begin
        day_c = len1;
      end else if (day_n == 5'd0) begin
        day_c = 5'd1;
      end
    end

    // January and February count as months of the previous year.
    wyear = year_sel + WEEK_YEAR_BIAS - ((month_n < 4'd3) ? 13'd1 : 13'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_s2.day   <= day_c;
      out_s2.month <= month_n;
      out_s2.yoff  <= yoff_n[6:0];
      out_s2.wyear <= wyear;
    end
  end

endmodule

// ===== rtl/cds_wday.sv =====
// Third and fourth stages: weekday sum with century terms, then modulo 7 into the output register.
module cds_wday (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cds_pkg::s2_t  in_s2,
  output logic          out_valid,
  input  logic          out_ready,
  output cds_pkg::res_t out_res
);
  import cds_pkg::*;

  logic             v3;
  s3_t              s3;
  logic             ready3;
  logic             ready4;
  logic [10:0]      quarter;
  logic [6:0]       q100;
  logic [6:0]       q400;
  logic [13:0]      acc;
  logic [2:0]       rem;

  assign ready4   = !out_valid || out_ready;
  assign ready3   = !v3 || ready4;
  assign in_ready = ready3;

  always_comb begin
    quarter = in_s2.wyear[12:2];
    q100    = div25(quarter);
    q400    = div25(11'(in_s2.wyear[12:4]));
    acc     = 14'(in_s2.wyear) + 14'(quarter) - 14'(q100) + 14'(q400)
            + 14'(month_off(in_s2.month)) + 14'(in_s2.day);
    rem     = mod7(s3.sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready3) begin
        v3 <= in_valid;
      end
      if (ready4) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && in_valid) begin
      s3.day   <= in_s2.day;
      s3.month <= in_s2.month;
      s3.yoff  <= in_s2.yoff;
      s3.sum   <= acc[12:0];
    end
    if (ready4 && v3) begin
      out_res.day     <= s3.day;
      out_res.month   <= s3.month;
      out_res.year    <= s3.yoff;
      out_res.weekday <= (rem == 3'd0) ? 3'd7 : rem;
    end
  end

endmodule
